// ===== design/gdu_pkg.sv =====
`timescale 1ns / 1ps

package gdu_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned DiffW  = 15;
  localparam int unsigned CountW = 22;

  // shared multiplier operand widths
  localparam int unsigned MulAW = 15;
  localparam int unsigned MulBW = 13;
  localparam int unsigned MulPW = MulAW + MulBW;

  localparam logic [YearW-1:0]  YearMax       = 14'd9999;
  localparam logic [YearW-1:0]  EarliestReset = 14'd1582;
  localparam logic [MonthW-1:0] MonthsPerYear = 4'd12;

  // x / 100 == (x * 5243) >> 19, exact for x below 2^15
  localparam logic [MulBW-1:0] Recip100     = 13'd5243;
  localparam int unsigned      Recip100Shft = 19;
  localparam logic [MulBW-1:0] DaysPerYear  = 13'd365;
  localparam logic [MulAW-1:0] CeilBias100  = 15'd99;

  typedef enum logic [1:0] {
    CMD_VALIDATE = 2'd0,
    CMD_NEXT     = 2'd1,
    CMD_COMPARE  = 2'd2,
    CMD_COUNT    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_FLOOR,
    ST_MUL_CEIL,
    ST_MUL_YEAR,
    ST_ACC_YEAR,
    ST_ACC_MONTH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } date_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_status_t;

  typedef struct packed {
    logic              is_valid;
    logic [DayW-1:0]   next_day;
    logic [MonthW-1:0] next_month;
    logic [YearW-1:0]  next_year;
    logic [DiffW-1:0]  compare_diff;
    logic [CountW-1:0] day_count;
    logic              error;
    logic              overflow;
  } result_t;

  function automatic logic month_ok(input logic [MonthW-1:0] m);
    return m inside {[4'd1:4'd12]};
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m, input logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // days in the year before day 1 of month m, common year
  function automatic logic [8:0] days_before(input logic [MonthW-1:0] m);
    logic [8:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  function automatic logic date_ok(input date_t dt, input logic leap,
                                   input logic [YearW-1:0] earliest);
    return (dt.year >= earliest) && (dt.year <= YearMax) && month_ok(dt.month) &&
           (dt.day != '0) && (dt.day <= month_len(dt.month, leap));
  endfunction

endpackage

// ===== design/gdu_mul.sv =====
`timescale 1ns / 1ps

// shared multiplier, one registered product per cycle
module gdu_mul import gdu_pkg::*; (
  input  logic             clk_i,
  input  logic [MulAW-1:0] op_a_i,
  input  logic [MulBW-1:0] op_b_i,
  output logic [MulPW-1:0] prod_o
);

  logic [MulPW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= MulPW'(op_a_i) * MulPW'(op_b_i);
  end

  assign prod_o = prod_q;

endmodule

// ===== design/gdu_seq.sv =====
`timescale 1ns / 1ps

// sequencer and datapath around the shared multiplier
module gdu_seq import gdu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  cmd_e              cmd_i,
  input  date_t             date_a_i,
  input  date_t             date_b_i,
  input  logic [YearW-1:0]  earliest_i,
  input  logic              take_i,
  output seq_status_t       status_o,
  output result_t           result_o
);

  state_e state_q, state_d;
  logic   sel_b_q, sel_b_d;

  cmd_e              cmd_q;
  date_t             date_a_q, date_b_q;
  logic [7:0]        floor_q, ceil_q;
  logic              leap_a_q, leap_b_q;
  logic [CountW-1:0] acc_q, num_a_q, num_b_q;

  date_t             cur;
  logic              cur_leap;
  logic [MulAW-1:0]  mul_a;
  logic [MulBW-1:0]  mul_b;
  logic [MulPW-1:0]  prod;
  logic [7:0]        quot;
  logic              leap_now;
  logic [MulAW-1:0]  y_bias;
  logic [8:0]        c_bias;
  logic [CountW-1:0] acc_year, acc_month;

  gdu_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  assign cur      = sel_b_q ? date_b_q : date_a_q;
  assign cur_leap = sel_b_q ? leap_b_q : leap_a_q;
  assign quot     = prod[Recip100Shft+7:Recip100Shft];

  always_comb begin
    mul_a = MulAW'(cur.year);
    mul_b = Recip100;
    case (state_q)
      ST_MUL_CEIL: mul_a = MulAW'(cur.year) + CeilBias100;
      ST_MUL_YEAR: mul_b = DaysPerYear;
      default: ;
    endcase
  end

  // floor(y/100) == ceil(y/100) exactly when y is a multiple of 100
  assign leap_now = (cur.year[1:0] == 2'b00) &&
                    ((quot != floor_q) || (floor_q[1:0] == 2'b00));

  // 365y + ceil(y/4) - ceil(y/100) + ceil(y/400)
  assign y_bias   = MulAW'(cur.year) + MulAW'(3);
  assign c_bias   = {1'b0, ceil_q} + 9'd3;
  assign acc_year = prod[CountW-1:0] + CountW'(y_bias[MulAW-1:2]) - CountW'(ceil_q) +
                    CountW'(c_bias[8:2]);
  assign acc_month = acc_q + CountW'(days_before(cur.month)) +
                     CountW'(cur_leap && (cur.month > 4'd2)) +
                     CountW'(cur.day) - CountW'(1);

  always_comb begin
    state_d = state_q;
    sel_b_d = sel_b_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          sel_b_d = 1'b0;
          state_d = (cmd_i == CMD_COMPARE) ? ST_DONE : ST_MUL_FLOOR;
        end
      end
      ST_MUL_FLOOR: state_d = ST_MUL_CEIL;
      ST_MUL_CEIL:  state_d = ST_MUL_YEAR;
      ST_MUL_YEAR:  state_d = (cmd_q == CMD_COUNT) ? ST_ACC_YEAR : ST_DONE;
      ST_ACC_YEAR:  state_d = ST_ACC_MONTH;
      ST_ACC_MONTH: begin
        if (!sel_b_q) begin
          sel_b_d = 1'b1;
          state_d = ST_MUL_FLOOR;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (take_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_b_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_b_q <= sel_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      cmd_q    <= cmd_i;
      date_a_q <= date_a_i;
      date_b_q <= date_b_i;
    end
    if (state_q == ST_MUL_CEIL) floor_q <= quot;
    if (state_q == ST_MUL_YEAR) begin
      ceil_q <= quot;
      if (sel_b_q) leap_b_q <= leap_now;
      else         leap_a_q <= leap_now;
    end
    if (state_q == ST_ACC_YEAR) acc_q <= acc_year;
    if (state_q == ST_ACC_MONTH) begin
      if (sel_b_q) num_b_q <= acc_month;
      else         num_a_q <= acc_month;
    end
  end

  // result, formed while waiting in ST_DONE
  logic              valid_a, valid_b;
  logic [DayW:0]     nd_day;
  logic [MulAW-1:0]  nd_year;

  assign valid_a = date_ok(date_a_q, leap_a_q, earliest_i);
  assign valid_b = date_ok(date_b_q, leap_b_q, earliest_i);
  assign nd_day  = {1'b0, date_a_q.day} + (DayW+1)'(1);
  assign nd_year = MulAW'(date_a_q.year) + MulAW'(1);

  always_comb begin
    result_o = '0;
    case (cmd_q)
      CMD_VALIDATE: result_o.is_valid = valid_a;
      CMD_NEXT: begin
        if (!month_ok(date_a_q.month)) begin
          result_o.error = 1'b1;
        end else if (nd_day <= (DayW+1)'(month_len(date_a_q.month, leap_a_q))) begin
          result_o.next_day   = nd_day[DayW-1:0];
          result_o.next_month = date_a_q.month;
          result_o.next_year  = date_a_q.year;
        end else if (date_a_q.month != MonthsPerYear) begin
          result_o.next_day   = DayW'(1);
          result_o.next_month = date_a_q.month + MonthW'(1);
          result_o.next_year  = date_a_q.year;
        end else if (nd_year > MulAW'(YearMax)) begin
          result_o.overflow = 1'b1;
        end else begin
          result_o.next_day   = DayW'(1);
          result_o.next_month = MonthW'(1);
          result_o.next_year  = nd_year[YearW-1:0];
        end
      end
      CMD_COMPARE: begin
        if (date_a_q.year != date_b_q.year)
          result_o.compare_diff = DiffW'(date_a_q.year) - DiffW'(date_b_q.year);
        else if (date_a_q.month != date_b_q.month)
          result_o.compare_diff = DiffW'(date_a_q.month) - DiffW'(date_b_q.month);
        else
          result_o.compare_diff = DiffW'(date_a_q.day) - DiffW'(date_b_q.day);
      end
      CMD_COUNT: begin
        if (!(valid_a && valid_b))
          result_o.error = 1'b1;
        else if (num_a_q > num_b_q)
          result_o.day_count = num_a_q - num_b_q;
        else
          result_o.day_count = num_b_q - num_a_q;
      end
      default: ;
    endcase
  end

  assign status_o.idle = (state_q == ST_IDLE);
  assign status_o.done = (state_q == ST_DONE);

endmodule

// ===== design/gregorian_date_unit.sv =====
`timescale 1ns / 1ps

// Gregorian date unit. One input beat carries a command in s_axis_tuser and
// two dates in s_axis_tdata; one result beat follows on the master side.
// Commands: validate A, day after A, compare A with B, days between A and B.
// Leap years follow the 400/100/4 rule. The input is taken only while the
// sequencer is idle, and one beat is worked at a time through a single
// shared multiplier (divide by 100 via reciprocal, then 365*year).
// Compare goes straight to the result; validate and next first run the
// floor, ceil and year multiply steps for the leap flag; day count runs
// five steps for each of its two day numbers (floor, ceil, year, year sum,
// month sum). The input is ready again once the result has entered the
// output register, so a new beat is not taken before the last one is done.
// The output register lets a new beat be taken while a result waits.
// The earliest-year register (reset 1582) is written through cfg_*; write
// it only while the unit is idle, which the block itself does not enforce.
// cfg_ready_o is always high.

module gregorian_date_unit import gdu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration: earliest year accepted as valid
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [YearW-1:0]  cfg_data_i,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // [4:0] day_a, [8:5] month_a, [22:9] year_a,
  // [27:23] day_b, [31:28] month_b, [45:32] year_b, [47:46] zero
  input  logic [47:0]       s_axis_tdata,
  // [1:0] cmd
  input  logic [1:0]        s_axis_tuser,
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [0] is_valid, [5:1] next_day, [9:6] next_month, [23:10] next_year,
  // [38:24] compare_diff, [60:39] day_count, [61] error, [62] overflow,
  // [63] zero
  output logic [63:0]       m_axis_tdata
);

  logic [YearW-1:0] earliest_q;
  logic             out_valid_q;
  result_t          out_res_q;

  seq_status_t status;
  result_t     result;
  logic        start, take, out_free;
  date_t       date_a, date_b;

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      earliest_q <= EarliestReset;
    end else if (cfg_valid_i) begin
      earliest_q <= cfg_data_i;
    end
  end

  // unpack the input beat
  assign date_a.day   = s_axis_tdata[4:0];
  assign date_a.month = s_axis_tdata[8:5];
  assign date_a.year  = s_axis_tdata[22:9];
  assign date_b.day   = s_axis_tdata[27:23];
  assign date_b.month = s_axis_tdata[31:28];
  assign date_b.year  = s_axis_tdata[45:32];

  assign s_axis_tready = status.idle;
  assign start         = s_axis_tvalid && status.idle;

  // output register: loads a finished result when empty or being drained
  assign out_free = !out_valid_q || m_axis_tready;
  assign take     = status.done && out_free;

  gdu_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .cmd_i      (cmd_e'(s_axis_tuser)),
    .date_a_i   (date_a),
    .date_b_i   (date_b),
    .earliest_i (earliest_q),
    .take_i     (take),
    .status_o   (status),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= status.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) out_res_q <= result;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0,
                          out_res_q.overflow,
                          out_res_q.error,
                          out_res_q.day_count,
                          out_res_q.compare_diff,
                          out_res_q.next_year,
                          out_res_q.next_month,
                          out_res_q.next_day,
                          out_res_q.is_valid};

endmodule

// ===== tb/gregorian_date_unit_checker.sv =====
`timescale 1ns / 1ps

// Watches the config, input and result channels of the date unit, predicts
// one result per input beat and compares result beats in order.
module gregorian_date_unit_checker import gdu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [YearW-1:0] cfg_data_i,
  input  logic             s_tvalid_i,
  input  logic             s_tready_i,
  input  logic [47:0]      s_tdata_i,
  input  logic [1:0]       s_tuser_i,
  input  logic             m_tvalid_i,
  input  logic             m_tready_i,
  input  logic [63:0]      m_tdata_i,
  output int               pending_o,
  output int               fail_count_o
);

  logic [YearW-1:0] first_year_q;
  result_t          expected_q[$];
  int               mismatches = 0;
  int               result_idx = 0;

  assign fail_count_o = mismatches;

  function automatic bit leap_of(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in(input int unsigned m, input int unsigned y);
    case (m)
      2:           return leap_of(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic bit date_valid(input date_t dt, input int unsigned first);
    if (dt.year < first || dt.year > YearMax) return 1'b0;
    if (dt.month < 1 || dt.month > MonthsPerYear) return 1'b0;
    return (dt.day >= 1) && (dt.day <= days_in(32'(dt.month), 32'(dt.year)));
  endfunction

  // days since 1 Jan of year 0
  function automatic int unsigned day_ordinal(input date_t dt);
    int unsigned y, n;
    y = 32'(dt.year);
    n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    for (int unsigned k = 1; k < dt.month; k++) n += days_in(k, y);
    return n + 32'(dt.day) - 1;
  endfunction

  function automatic result_t predict_result(input cmd_e cmd, input date_t a, input date_t b,
                                             input int unsigned first);
    result_t     r;
    int unsigned d, m, y, na, nb;
    int          diff;
    r = '0;
    case (cmd)
      CMD_VALIDATE: r.is_valid = date_valid(a, first);
      CMD_NEXT: begin
        if (a.month < 1 || a.month > MonthsPerYear) begin
          r.error = 1'b1;
        end else begin
          d = 32'(a.day) + 1;
          m = 32'(a.month);
          y = 32'(a.year);
          if (d > days_in(m, y)) begin
            d = 1;
            m++;
            // only a carry into the year can overflow
            if (m > MonthsPerYear) begin
              m = 1;
              y++;
              r.overflow = (y > YearMax);
            end
          end
          if (!r.overflow) begin
            r.next_day   = DayW'(d);
            r.next_month = MonthW'(m);
            r.next_year  = YearW'(y);
          end
        end
      end
      CMD_COMPARE: begin
        if (a.year != b.year)        diff = int'(a.year) - int'(b.year);
        else if (a.month != b.month) diff = int'(a.month) - int'(b.month);
        else                         diff = int'(a.day) - int'(b.day);
        r.compare_diff = diff[DiffW-1:0];
      end
      CMD_COUNT: begin
        if (!date_valid(a, first) || !date_valid(b, first)) begin
          r.error = 1'b1;
        end else begin
          na = day_ordinal(a);
          nb = day_ordinal(b);
          r.day_count = CountW'((na > nb) ? na - nb : nb - na);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic date_t unpack_date(input logic [22:0] bits);
    date_t dt;
    dt.day   = bits[4:0];
    dt.month = bits[8:5];
    dt.year  = bits[22:9];
    return dt;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string field, input longint got, input longint want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got %0d, want %0d", result_idx, field, got,
                                want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      first_year_q <= EarliestReset;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) first_year_q <= cfg_data_i;
      if (s_tvalid_i && s_tready_i)
        expected_q.push_back(predict_result(cmd_e'(s_tuser_i), unpack_date(s_tdata_i[22:0]),
                                            unpack_date(s_tdata_i[45:23]),
                                            32'(first_year_q)));
      if (m_tvalid_i && m_tready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", result_idx));
        end else begin
          want = expected_q.pop_front();
          check_field("is_valid", longint'(m_tdata_i[0]), longint'(want.is_valid));
          check_field("next_day", longint'(m_tdata_i[5:1]), longint'(want.next_day));
          check_field("next_month", longint'(m_tdata_i[9:6]), longint'(want.next_month));
          check_field("next_year", longint'(m_tdata_i[23:10]), longint'(want.next_year));
          check_field("compare_diff", longint'($signed(m_tdata_i[38:24])),
                      longint'($signed(want.compare_diff)));
          check_field("day_count", longint'(m_tdata_i[60:39]), longint'(want.day_count));
          check_field("error", longint'(m_tdata_i[61]), longint'(want.error));
          check_field("overflow", longint'(m_tdata_i[62]), longint'(want.overflow));
        end
        result_idx++;
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

// ===== tb/gregorian_date_unit_tb.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the date unit. A directed set of beats runs under
// the reset earliest year, then six random segments follow, each under its
// own earliest year and one of three idling patterns. All checking lives in
// the checker instance beside the unit.
module gregorian_date_unit_tb import gdu_pkg::*; ();

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_valid = 1'b0;
  logic [YearW-1:0] cfg_data  = '0;
  logic             s_tvalid  = 1'b0;
  logic [47:0]      s_tdata   = '0;
  logic [1:0]       s_tuser   = '0;
  logic             m_tready  = 1'b0;
  logic             cfg_ready;
  logic             s_tready;
  logic             m_tvalid;
  logic [63:0]      m_tdata;

  // idling, in cycles out of a hundred
  int               tx_idle_pct = 0;
  int               rx_idle_pct = 0;
  // stimulus-side copy of the earliest year, steers the random dates
  logic [YearW-1:0] first_year  = EarliestReset;
  int               pending;
  int               fail_count;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  gregorian_date_unit i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  gregorian_date_unit_checker i_result_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // result side back-pressure, redrawn every cycle
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // hard stop, far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic date_t mk_date(input int unsigned d, input int unsigned m,
                                    input int unsigned y);
    date_t dt;
    dt.day   = DayW'(d);
    dt.month = MonthW'(m);
    dt.year  = YearW'(y);
    return dt;
  endfunction

  // any field values at all, out-of-range months and years included
  function automatic date_t any_date();
    return mk_date($urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 16383));
  endfunction

  // mostly valid under the given earliest year; days lean towards month ends
  // and years towards the leap-rule boundaries
  function automatic date_t good_date(input int unsigned first);
    date_t       dt;
    int unsigned y;
    if (first > YearMax) return any_date();
    y = $urandom_range(YearMax, first);
    case ($urandom_range(0, 5))
      0: y = first;
      1: y = YearMax;
      2: if (y - y % 4 >= first) y = y - y % 4;
      3: if (y - y % 100 >= first) y = y - y % 100;
      4: if (y - y % 400 >= first) y = y - y % 400;
      default: ;
    endcase
    dt.year  = YearW'(y);
    dt.month = MonthW'($urandom_range(1, 12));
    dt.day   = DayW'($urandom_range(0, 1) ? $urandom_range(1, 28) : $urandom_range(28, 31));
    return dt;
  endfunction

  // one input beat; called on a rising edge, returns on one. Valid is only
  // dropped when a gap follows, so back-to-back beats keep it high.
  task automatic send_beat(input cmd_e cmd, input date_t a, input date_t b);
    int gap;
    s_tdata  <= {2'b00, b.year, b.month, b.day, a.year, a.month, a.day};
    s_tuser  <= cmd;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    gap = 0;
    while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_first_year(input logic [YearW-1:0] value);
    first_year = value;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // the count read after the next edge already holds beats taken at this edge
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  initial begin
    date_t            a, b;
    cmd_e             cmd;
    bit               noise;
    logic [YearW-1:0] seg_first [6];

    seg_first = '{14'd0, 14'd9999, 14'($urandom_range(0, 9999)), 14'd16383, 14'd1, 14'd1582};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats under the reset earliest year
    // validity: year bounds, leap rule, short months, day zero, bad months
    send_beat(CMD_VALIDATE, mk_date(1, 1, 1582), mk_date(0, 0, 0));
    send_beat(CMD_VALIDATE, mk_date(31, 12, 1581), mk_date(0, 0, 0));
    send_beat(CMD_VALIDATE, mk_date(29, 2, 2000), mk_date(0, 0, 0));
    send_beat(CMD_VALIDATE, mk_date(29, 2, 1900), mk_date(0, 0, 0));
    send_beat(CMD_VALIDATE, mk_date(31, 4, 2021), mk_date(0, 0, 0));
    send_beat(CMD_VALIDATE, mk_date(0, 6, 2020), mk_date(0, 0, 0));
    send_beat(CMD_VALIDATE, mk_date(31, 15, 16383), mk_date(31, 15, 16383));
    send_beat(CMD_VALIDATE, mk_date(31, 12, 9999), mk_date(0, 0, 0));
    send_beat(CMD_VALIDATE, mk_date(1, 1, 10000), mk_date(0, 0, 0));
    // next day: year and month roll, Feb in leap and common years, day zero,
    // an odd day past the month end, bad months, overflow, an oversize year
    send_beat(CMD_NEXT, mk_date(31, 12, 2023), mk_date(0, 0, 0));
    send_beat(CMD_NEXT, mk_date(28, 2, 2024), mk_date(0, 0, 0));
    send_beat(CMD_NEXT, mk_date(29, 2, 2023), mk_date(0, 0, 0));
    send_beat(CMD_NEXT, mk_date(28, 2, 1900), mk_date(0, 0, 0));
    send_beat(CMD_NEXT, mk_date(0, 5, 2020), mk_date(0, 0, 0));
    send_beat(CMD_NEXT, mk_date(31, 4, 2021), mk_date(0, 0, 0));
    send_beat(CMD_NEXT, mk_date(15, 0, 2020), mk_date(0, 0, 0));
    send_beat(CMD_NEXT, mk_date(10, 13, 16383), mk_date(0, 0, 0));
    send_beat(CMD_NEXT, mk_date(31, 12, 9999), mk_date(0, 0, 0));
    send_beat(CMD_NEXT, mk_date(5, 6, 16383), mk_date(0, 0, 0));
    // compare: widest year gaps both ways, month, day, equal
    send_beat(CMD_COMPARE, mk_date(0, 0, 0), mk_date(31, 15, 16383));
    send_beat(CMD_COMPARE, mk_date(31, 15, 16383), mk_date(0, 0, 0));
    send_beat(CMD_COMPARE, mk_date(5, 3, 2020), mk_date(5, 11, 2020));
    send_beat(CMD_COMPARE, mk_date(31, 7, 2020), mk_date(0, 7, 2020));
    send_beat(CMD_COMPARE, mk_date(9, 9, 1999), mk_date(9, 9, 1999));
    // count: full span both orders, invalid A, invalid B, same date
    send_beat(CMD_COUNT, mk_date(1, 1, 1582), mk_date(31, 12, 9999));
    send_beat(CMD_COUNT, mk_date(31, 12, 9999), mk_date(1, 1, 1582));
    send_beat(CMD_COUNT, mk_date(29, 2, 1900), mk_date(1, 1, 2000));
    send_beat(CMD_COUNT, mk_date(1, 1, 2000), mk_date(1, 1, 1500));
    send_beat(CMD_COUNT, mk_date(29, 2, 2024), mk_date(29, 2, 2024));

    // random segments: sender idles lightly and receiver heavily, then the
    // reverse, then no idling; earliest year rewritten before each
    for (int seg = 0; seg < 6; seg++) begin
      wait_drained();
      tx_idle_pct = (seg < 2) ? 16 : (seg < 4) ? 68 : 0;
      rx_idle_pct <= (seg < 2) ? 68 : (seg < 4) ? 16 : 0;
      write_first_year(seg_first[seg]);
      repeat (190) begin
        cmd   = cmd_e'(2'($urandom_range(0, 3)));
        noise = ($urandom_range(99) < 20);
        a     = noise ? any_date() : good_date(32'(first_year));
        b     = any_date();
        case (cmd)
          CMD_NEXT: begin
            // steer some beats onto the year end
            if (!noise && $urandom_range(0, 9) == 0) begin
              a.month = MonthsPerYear;
              a.day   = DayW'(31);
            end
          end
          CMD_COMPARE: begin
            case ($urandom_range(0, 3))
              0: b = a;
              1: begin
                b.year  = a.year;
                b.month = a.month;
              end
              2: b.year = a.year;
              default: ;
            endcase
          end
          CMD_COUNT: begin
            if ($urandom_range(99) >= 15) b = good_date(32'(first_year));
            if ($urandom_range(3) == 0) b.year = a.year;
          end
          default: ;
        endcase
        send_beat(cmd, a, b);
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
